@@ rtl/ttw_pkg.sv @@
// ----------------------------------------------------------------------------
// ttw_pkg
// Shared types and constants of the text terminal writer: command classes,
// queue entries and the character codes the front and back ends act on.
// ----------------------------------------------------------------------------
package ttw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] RESET_COLOR  = 8'h0F;

  typedef enum logic [1:0] {
    OP_READ      = 2'd0,
    OP_NEWLINE   = 2'd1,
    OP_BACKSPACE = 2'd2,
    OP_PRINT     = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  ch;
    logic [10:0] idx;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } push_t;

  typedef struct packed {
    logic  empty;
    logic  full;
    item_t item;
  } q_status_t;

endpackage

@@ rtl/text_terminal_writer.sv @@
// ----------------------------------------------------------------------------
// text_terminal_writer
// Text screen of ROWS x COLUMNS 16-bit cells with a write cursor. Commands
// are classified by a front end, queued, and carried out by a back end that
// owns the screen memory.
//
//   channel   signals                                   beat taken when
//   command   start, busy, command, char_code,          start && !busy
//             cell_index
//   result    done, cell_word, cursor_row,              done (one cycle)
//             cursor_col, scrolled
//   config    cfg_valid, cfg_ready, cfg_data            cfg_valid && cfg_ready
//
// A write command is carried out as it leaves the queue, and a read waits
// on the registered read port of the screen memory; the two-entry queue
// lets the front end take commands while the back end works.
// A scroll copies each cell up one row, a read state and then a write
// state per cell through the read and write ports, and then blanks the
// last row. After reset a clearing pass over all ROWS*COLUMNS cells runs
// before the first command executes; commands are still queued until busy
// rises.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module text_terminal_writer
  import ttw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [7:0]  char_code,
  input  logic [10:0] cell_index,
  output logic        done,
  output logic [15:0] cell_word,
  output logic [4:0]  cursor_row,
  output logic [6:0]  cursor_col,
  output logic        scrolled,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  push_t     push;
  q_status_t q;
  logic      pop;

  assign cfg_ready = 1'b1;

  ttw_front u_front (
    .start      (start),
    .command    (command),
    .char_code  (char_code),
    .cell_index (cell_index),
    .q_full     (q.full),
    .busy       (busy),
    .push       (push)
  );

  ttw_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .status (q)
  );

  ttw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q          (q),
    .pop        (pop),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .done       (done),
    .cell_word  (cell_word),
    .cursor_row (cursor_row),
    .cursor_col (cursor_col),
    .scrolled   (scrolled)
  );

endmodule

@@ rtl/ttw_ram.sv @@
// ----------------------------------------------------------------------------
// ttw_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ttw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/ttw_front.sv @@
// ----------------------------------------------------------------------------
// ttw_front
// Command front end: accepts commands and sorts each into read, newline,
// backspace or printable before it enters the queue.
// ----------------------------------------------------------------------------
module ttw_front
  import ttw_pkg::*;
(
  input  logic        start,
  input  logic        command,
  input  logic [7:0]  char_code,
  input  logic [10:0] cell_index,
  input  logic        q_full,
  output logic        busy,
  output push_t       push
);

  op_t op;

  always_comb begin
    if (command) begin
      op = OP_READ;
    end else if (char_code == CH_NEWLINE) begin
      op = OP_NEWLINE;
    end else if (char_code == CH_BACKSPACE) begin
      op = OP_BACKSPACE;
    end else begin
      op = OP_PRINT;
    end
  end

  assign busy          = q_full;
  assign push.push     = start && !q_full;
  assign push.item.op  = op;
  assign push.item.ch  = char_code;
  assign push.item.idx = cell_index;

endmodule

@@ rtl/ttw_queue.sv @@
// ----------------------------------------------------------------------------
// ttw_queue
// Short FIFO of classified commands between the front end and the back end.
// ----------------------------------------------------------------------------
module ttw_queue
  import ttw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  push_t     push,
  input  logic      pop,
  output q_status_t status
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t         entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.push) begin
        entries[wr_ptr] <= push.item;
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push.push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push.push) begin
        count <= count - CW'(1);
      end
    end
  end

  assign status.empty = (count == '0);
  assign status.full  = (count == CW'(QUEUE_DEPTH));
  assign status.item  = entries[rd_ptr];

endmodule

@@ rtl/ttw_back.sv @@
// ----------------------------------------------------------------------------
// ttw_back
// Execution back end: owns the screen memory, the cursor and the color
// register. Runs the clear pass after reset, the row copy of a scroll, and
// drives the result strobe.
// ----------------------------------------------------------------------------
module ttw_back
  import ttw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic        clk,
  input  logic        rst,
  input  q_status_t   q,
  output logic        pop,
  input  logic        cfg_valid,
  input  logic [7:0]  cfg_data,
  output logic        done,
  output logic [15:0] cell_word,
  output logic [4:0]  cursor_row,
  output logic [6:0]  cursor_col,
  output logic        scrolled
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_ADDR     = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW_ADDR = ADDR_W'(CELLS - COLUMNS);

  typedef enum logic [4:0] {
    ST_FILL   = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_READ   = 5'b00100,
    ST_SCR_RD = 5'b01000,
    ST_SCR_WR = 5'b10000
  } state_t;

  state_t            state;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] fill_addr;
  logic [ADDR_W-1:0] scr_addr;
  logic [7:0]        fill_color;
  logic              fill_report;
  logic [7:0]        color;

  logic [ROW_W-1:0]  row_next;
  logic [COL_W-1:0]  col_next;
  logic [ADDR_W-1:0] addr_next;
  logic              emit;
  logic              scroll_go;
  logic              read_go;
  logic              idx_ok;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [15:0]       wdata;
  logic [ADDR_W-1:0] raddr;
  logic [15:0]       rdata;

  ttw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign idx_ok = (32'(q.item.idx) < 32'(CELLS));

  // Cursor update and memory access for the command at the queue head, the clear pass and the scroll copy.
  always_comb begin
    row_next  = row;
    col_next  = col;
    addr_next = cur_addr;
    emit      = 1'b0;
    scroll_go = 1'b0;
    read_go   = 1'b0;
    pop       = 1'b0;
    we        = 1'b0;
    waddr     = cur_addr;
    wdata     = {color, CH_SPACE};
    raddr     = scr_addr;
    case (state)
      ST_FILL: begin
        we    = 1'b1;
        waddr = fill_addr;
        wdata = {fill_color, CH_SPACE};
      end
      ST_IDLE: begin
        if (!q.empty) begin
          pop = 1'b1;
          case (q.item.op)
            OP_READ: begin
              raddr = ADDR_W'(q.item.idx);
              if (idx_ok) begin
                read_go = 1'b1;
              end else begin
                emit = 1'b1;
              end
            end
            OP_NEWLINE: begin
              col_next = '0;
              if (row == ROW_W'(ROWS - 1)) begin
                scroll_go = 1'b1;
                addr_next = LAST_ROW_ADDR;
              end else begin
                emit      = 1'b1;
                row_next  = row + ROW_W'(1);
                addr_next = cur_addr - ADDR_W'(col) + ADDR_W'(COLUMNS);
              end
            end
            OP_BACKSPACE: begin
              emit = 1'b1;
              // The top-left corner leaves everything as it is.
              if (row != '0 || col != '0) begin
                we        = 1'b1;
                waddr     = cur_addr - ADDR_W'(1);
                addr_next = cur_addr - ADDR_W'(1);
                if (col == '0) begin
                  row_next = row - ROW_W'(1);
                  col_next = COL_W'(COLUMNS - 1);
                end else begin
                  col_next = col - COL_W'(1);
                end
              end
            end
            OP_PRINT: begin
              we    = 1'b1;
              waddr = cur_addr;
              wdata = {color, q.item.ch};
              if (col == COL_W'(COLUMNS - 1)) begin
                col_next = '0;
                if (row == ROW_W'(ROWS - 1)) begin
                  scroll_go = 1'b1;
                  addr_next = LAST_ROW_ADDR;
                end else begin
                  emit      = 1'b1;
                  row_next  = row + ROW_W'(1);
                  addr_next = cur_addr + ADDR_W'(1);
                end
              end else begin
                emit      = 1'b1;
                col_next  = col + COL_W'(1);
                addr_next = cur_addr + ADDR_W'(1);
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCR_RD: begin
        raddr = scr_addr;
      end
      ST_SCR_WR: begin
        we    = 1'b1;
        waddr = scr_addr - ADDR_W'(COLUMNS);
        wdata = {color, rdata[7:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_FILL;
      fill_addr   <= '0;
      fill_color  <= RESET_COLOR;
      fill_report <= 1'b0;
      row         <= '0;
      col         <= '0;
      cur_addr    <= '0;
      color       <= RESET_COLOR;
      done        <= 1'b0;
    end else begin
      // Strobe for each result; the blanking of the last row ends a scroll and reports it.
      done <= emit || (state == ST_READ) ||
              (state == ST_FILL && fill_addr == LAST_ADDR && fill_report);
      if (cfg_valid) begin
        color <= cfg_data;
      end
      row      <= row_next;
      col      <= col_next;
      cur_addr <= addr_next;
      if (emit) begin
        cell_word  <= '0;
        cursor_row <= 5'(row_next);
        cursor_col <= 7'(col_next);
        scrolled   <= 1'b0;
      end
      case (state)
        ST_FILL: begin
          fill_addr <= fill_addr + ADDR_W'(1);
          if (fill_addr == LAST_ADDR) begin
            state <= ST_IDLE;
            if (fill_report) begin
              cell_word  <= '0;
              cursor_row <= 5'(row);
              cursor_col <= 7'(col);
              scrolled   <= 1'b1;
            end
          end
        end
        ST_IDLE: begin
          if (read_go) begin
            state <= ST_READ;
          end else if (scroll_go) begin
            state    <= ST_SCR_RD;
            scr_addr <= ADDR_W'(COLUMNS);
          end
        end
        ST_READ: begin
          state      <= ST_IDLE;
          cell_word  <= rdata;
          cursor_row <= 5'(row);
          cursor_col <= 7'(col);
          scrolled   <= 1'b0;
        end
        ST_SCR_RD: begin
          state <= ST_SCR_WR;
        end
        ST_SCR_WR: begin
          scr_addr <= scr_addr + ADDR_W'(1);
          if (scr_addr == LAST_ADDR) begin
            state       <= ST_FILL;
            fill_addr   <= LAST_ROW_ADDR;
            fill_color  <= color;
            fill_report <= 1'b1;
          end else begin
            state <= ST_SCR_RD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
